// ===== hdl/clt_pkg.sv =====
// types, codes and keyword tables shared by the command line tokenizer
`timescale 1ns / 1ps
package clt_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int OUT_POS_W     = 16;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_DOT    = 8'h2e;
    localparam logic [7:0] CHAR_BSLASH = 8'h5c;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_KEYWORD,
        MODE_NUMBER,
        MODE_STRING,
        MODE_ESCAPE
    } t_mode;

    typedef enum logic [1:0] {
        KW_GET,
        KW_SET,
        KW_TRUE,
        KW_FALSE
    } t_kw;

    typedef enum logic [3:0] {
        TK_EOF,
        TK_GET,
        TK_SET,
        TK_TRUE,
        TK_FALSE,
        TK_INT,
        TK_FLOAT,
        TK_STRING,
        TK_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_KEYWORD,
        ERR_UNTERM,
        ERR_UNEXP
    } t_err;

    typedef struct packed {
        t_kind                 kind;
        t_err                  err;
        logic [OUT_POS_W-1:0]  offset;
        logic [OUT_POS_W-1:0]  length;
        logic                  last;
    } t_token;

    typedef struct packed {
        t_token      tok0;
        t_token      tok1;
        logic [1:0]  count;
    } t_scan_out;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [2:0] kw_len(input t_kw t);
        logic [2:0] r;
        case (t)
            KW_GET:   r = 3'd2;
            KW_SET:   r = 3'd2;
            KW_TRUE:  r = 3'd3;
            default:  r = 3'd4;
        endcase
        return r;
    endfunction

    // letters after the first one of each keyword
    function automatic logic [7:0] kw_char(input t_kw t, input logic [1:0] k);
        logic [7:0] r;
        r = 8'h00;
        case (t)
            KW_GET, KW_SET: begin
                case (k)
                    2'd0:    r = 8'h45;
                    2'd1:    r = 8'h54;
                    default: r = 8'h00;
                endcase
            end
            KW_TRUE: begin
                case (k)
                    2'd0:    r = 8'h72;
                    2'd1:    r = 8'h75;
                    2'd2:    r = 8'h65;
                    default: r = 8'h00;
                endcase
            end
            default: begin
                case (k)
                    2'd0:    r = 8'h61;
                    2'd1:    r = 8'h6c;
                    2'd2:    r = 8'h73;
                    default: r = 8'h65;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic t_kind kw_kind(input t_kw t);
        t_kind r;
        case (t)
            KW_GET:   r = TK_GET;
            KW_SET:   r = TK_SET;
            KW_TRUE:  r = TK_TRUE;
            default:  r = TK_FALSE;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/clt_if.sv =====
// valid/ready channel interfaces for characters in and tokens out
`timescale 1ns / 1ps
interface clt_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface clt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [1:0]  error_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output error_kind, output token_offset,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input error_kind, input token_offset,
                  input token_length, input last_of_run, output ready);
endinterface

// ===== hdl/command_line_tokenizer.sv =====
// command line tokenizer top level: input register, scanner and result queue
//
// One character word enters per clock while the result queue has room. Each
// character is held in the input register and scanned once the four-word
// result queue has room for two words, which then takes its token words.
// A character yields zero, one or two token words; the output port moves one
// token word per clock while the receiver is ready, so the sustained rate is
// one character per clock while each yields at most one token; one that closes
// a pending token and also ends the line or is an unexpected byte yields two.
// last_of_run marks the final token word caused by one character.
`timescale 1ns / 1ps
module command_line_tokenizer import clt_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    clt_in_if.sink        i_in,
    clt_out_if.source     o_out
);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = FIFO_AW + 1;

    logic                  r_in_valid;
    logic [7:0]            r_char;
    t_token                r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_head;
    logic [FIFO_AW-1:0]    r_tail;
    logic [FIFO_CW-1:0]    r_count;
    logic [FIFO_CW-1:0]    n_count;

    logic                  w_fire;
    logic                  w_pop;
    logic                  w_accept;
    logic [1:0]            w_push;
    t_scan_out             w_scan;
    t_token                w_head;

    clt_scan #(
        .POS_WIDTH (POS_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_char  (r_char),
        .o_res   (w_scan)
    );

    assign w_fire = r_in_valid && (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign w_accept = i_in.valid && i_in.ready;
    assign w_pop = o_out.valid && o_out.ready;
    assign w_push = w_fire ? w_scan.count : 2'd0;
    assign n_count = r_count + FIFO_CW'(w_push) - FIFO_CW'(w_pop);

    assign i_in.ready = !r_in_valid || w_fire;

    assign w_head = r_fifo[r_head];
    assign o_out.valid = r_count != '0;
    assign o_out.token_kind = w_head.kind;
    assign o_out.error_kind = w_head.err;
    assign o_out.token_offset = w_head.offset;
    assign o_out.token_length = w_head.length;
    assign o_out.last_of_run = w_head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_pop) begin
                r_head <= r_head + FIFO_AW'(1);
            end
            r_tail <= r_tail + FIFO_AW'(w_push);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= i_in.char_in;
        end
        if (w_push != 2'd0) begin
            r_fifo[r_tail] <= w_scan.tok0;
        end
        if (w_push == 2'd2) begin
            r_fifo[r_tail + FIFO_AW'(1)] <= w_scan.tok1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // the newest queued word always closes the run of its character
    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_fifo[r_tail - FIFO_AW'(1)].last)
        else $error("queued run not closed");

    a_eol_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_char == CHAR_NUL) |-> (w_scan.count != 2'd0))
        else $error("end of line without eof word");

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted word lost from input register");

endmodule

// ===== hdl/clt_scan.sv =====
// scanner state and per-character token logic
`timescale 1ns / 1ps
module clt_scan import clt_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    output t_scan_out  o_res
);

    localparam int EXT_W = (POS_WIDTH + 1 > OUT_POS_W + 1) ? POS_WIDTH + 1 : OUT_POS_W + 1;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    t_mode                 r_mode, n_mode;
    t_kw                   r_kw_target, n_kw_target;
    logic                  r_kw_match, n_kw_match;
    logic [2:0]            r_kw_pos, n_kw_pos;
    logic                  r_dot, n_dot;
    logic [POS_WIDTH-1:0]  r_begin, n_begin;
    logic [POS_WIDTH-1:0]  r_line_pos, n_line_pos;

    logic                  w_taken;
    logic                  w_pend_valid;
    logic                  w_tail_valid;
    logic                  w_ws;
    logic                  w_kw_start;
    logic                  w_kw_hit;
    logic [POS_WIDTH:0]    w_len;
    logic [POS_WIDTH:0]    w_len_q;
    t_token                w_pend;
    t_token                w_tail;

    function automatic logic [OUT_POS_W-1:0] sat_pos(input logic [POS_WIDTH:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return (e > EXT_W'({OUT_POS_W{1'b1}})) ? {OUT_POS_W{1'b1}} : e[OUT_POS_W-1:0];
    endfunction

    assign w_ws = i_char == CHAR_SPACE || i_char == CHAR_TAB || i_char == CHAR_CR
                  || i_char == CHAR_LF;
    assign w_kw_start = i_char == 8'h47 || i_char == 8'h53 || i_char == 8'h74
                        || i_char == 8'h66;
    assign w_kw_hit = r_kw_match && r_kw_pos == kw_len(r_kw_target);
    assign w_len = {1'b0, r_line_pos} - {1'b0, r_begin};
    assign w_len_q = {1'b0, r_line_pos} + (POS_WIDTH + 1)'(1) - {1'b0, r_begin};

    always_comb begin
        w_taken = 1'b0;
        w_pend_valid = 1'b0;
        case (r_mode)
            MODE_KEYWORD: begin
                w_taken = is_letter(i_char);
                w_pend_valid = !is_letter(i_char);
            end
            MODE_NUMBER: begin
                w_taken = is_numeral(i_char) || i_char == CHAR_DOT;
                w_pend_valid = !(is_numeral(i_char) || i_char == CHAR_DOT);
            end
            MODE_STRING: begin
                w_taken = i_char != CHAR_NUL;
                w_pend_valid = i_char == CHAR_NUL || i_char == CHAR_QUOTE;
            end
            MODE_ESCAPE: begin
                w_taken = i_char != CHAR_NUL;
                w_pend_valid = i_char == CHAR_NUL;
            end
            default: begin
                w_taken = 1'b0;
                w_pend_valid = 1'b0;
            end
        endcase
    end

    assign w_tail_valid = !w_taken && (i_char == CHAR_NUL
                          || !(w_ws || i_char == CHAR_QUOTE || w_kw_start || is_numeral(i_char)));

    // next state
    always_comb begin
        n_mode = r_mode;
        n_kw_target = r_kw_target;
        n_kw_match = r_kw_match;
        n_kw_pos = r_kw_pos;
        n_dot = r_dot;
        n_begin = r_begin;
        n_line_pos = (r_line_pos < POS_MAX) ? r_line_pos + POS_WIDTH'(1) : POS_MAX;
        case (r_mode)
            MODE_KEYWORD: begin
                if (is_letter(i_char)) begin
                    if (!(r_kw_pos < kw_len(r_kw_target)
                          && i_char == kw_char(r_kw_target, r_kw_pos[1:0]))) begin
                        n_kw_match = 1'b0;
                    end
                    if (r_kw_pos < 3'd7) begin
                        n_kw_pos = r_kw_pos + 3'd1;
                    end
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (i_char == CHAR_DOT) begin
                    n_dot = 1'b1;
                end else if (!is_numeral(i_char)) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_STRING, MODE_ESCAPE: begin
                if (i_char == CHAR_NUL) begin
                    n_mode = MODE_IDLE;
                end else if (i_char == CHAR_QUOTE && r_mode == MODE_STRING) begin
                    n_mode = MODE_IDLE;
                end else begin
                    n_mode = (i_char == CHAR_BSLASH) ? MODE_ESCAPE : MODE_STRING;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
        if (!w_taken) begin
            if (i_char == CHAR_NUL) begin
                n_mode = MODE_IDLE;
                n_kw_target = KW_GET;
                n_kw_match = 1'b0;
                n_kw_pos = 3'd0;
                n_dot = 1'b0;
                n_begin = '0;
                n_line_pos = '0;
            end else if (i_char == CHAR_QUOTE) begin
                n_mode = MODE_STRING;
                n_begin = r_line_pos;
            end else if (w_kw_start) begin
                n_mode = MODE_KEYWORD;
                n_kw_target = (i_char == 8'h47) ? KW_GET :
                              (i_char == 8'h53) ? KW_SET :
                              (i_char == 8'h74) ? KW_TRUE : KW_FALSE;
                n_kw_match = 1'b1;
                n_kw_pos = 3'd0;
                n_begin = r_line_pos;
            end else if (is_numeral(i_char)) begin
                n_mode = MODE_NUMBER;
                n_dot = 1'b0;
                n_begin = r_line_pos;
            end
        end
    end

    // result words
    always_comb begin
        w_pend.kind = TK_ERROR;
        w_pend.err = ERR_NONE;
        w_pend.offset = sat_pos({1'b0, r_begin});
        w_pend.length = sat_pos(w_len);
        w_pend.last = 1'b0;
        case (r_mode)
            MODE_KEYWORD: begin
                w_pend.kind = w_kw_hit ? kw_kind(r_kw_target) : TK_ERROR;
                w_pend.err = w_kw_hit ? ERR_NONE : ERR_KEYWORD;
            end
            MODE_NUMBER: begin
                w_pend.kind = r_dot ? TK_FLOAT : TK_INT;
            end
            MODE_STRING, MODE_ESCAPE: begin
                if (i_char == CHAR_NUL) begin
                    w_pend.kind = TK_ERROR;
                    w_pend.err = ERR_UNTERM;
                end else begin
                    w_pend.kind = TK_STRING;
                    w_pend.length = sat_pos(w_len_q);
                end
            end
            default: begin
                w_pend.kind = TK_ERROR;
            end
        endcase

        w_tail.kind = (i_char == CHAR_NUL) ? TK_EOF : TK_ERROR;
        w_tail.err = (i_char == CHAR_NUL) ? ERR_NONE : ERR_UNEXP;
        w_tail.offset = sat_pos({1'b0, r_line_pos});
        w_tail.length = (i_char == CHAR_NUL) ? '0 : OUT_POS_W'(1);
        w_tail.last = 1'b1;

        if (w_pend_valid) begin
            o_res.tok0 = w_pend;
            o_res.tok0.last = !w_tail_valid;
            o_res.tok1 = w_tail;
            o_res.count = w_tail_valid ? 2'd2 : 2'd1;
        end else begin
            o_res.tok0 = w_tail;
            o_res.tok1 = w_tail;
            o_res.count = w_tail_valid ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_kw_target <= KW_GET;
            r_kw_match <= 1'b0;
            r_kw_pos <= 3'd0;
            r_dot <= 1'b0;
            r_begin <= '0;
            r_line_pos <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_kw_target <= n_kw_target;
            r_kw_match <= n_kw_match;
            r_kw_pos <= n_kw_pos;
            r_dot <= n_dot;
            r_begin <= n_begin;
            r_line_pos <= n_line_pos;
        end
    end

    // token start never lies past the current position
    a_begin_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_begin <= r_line_pos)
        else $error("token start beyond line position");

    // end of line always returns the scanner to its start state
    a_eol_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_char == CHAR_NUL) |=> (r_mode == MODE_IDLE && r_line_pos == '0))
        else $error("end of line did not reset scanner");

endmodule

// ===== tb/token_checker.sv =====
// token predictor and scoreboard that watches the character and token channels
`timescale 1ns / 1ps
module token_checker import clt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    clt_in_if     i_in_mon,
    clt_out_if    i_out_mon,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);

    localparam logic [15:0] LINE_POS_MAX = 16'hffff;

    t_mode       scan_mode;
    t_kw         kw_target;
    bit          kw_match;
    logic [2:0]  kw_pos;
    bit          dot_seen;
    logic [15:0] tok_begin;
    logic [15:0] line_pos;
    t_token      expected_tokens[$];
    int          fail_total;
    int          checked_total;

    string kw_spelling[4] = '{"GET", "SET", "true", "false"};
    t_kind kw_token[4]    = '{TK_GET, TK_SET, TK_TRUE, TK_FALSE};

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_num_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_scanner();
        scan_mode = MODE_IDLE;
        kw_target = KW_GET;
        kw_match  = 1'b0;
        kw_pos    = '0;
        dot_seen  = 1'b0;
        tok_begin = '0;
        line_pos  = '0;
    endfunction

    function automatic void push_token(input t_kind kind, input t_err err,
                                       input int unsigned off, input int unsigned len);
        t_token t;
        t.kind   = kind;
        t.err    = err;
        t.offset = (off > 65535) ? 16'hffff : off[15:0];
        t.length = (len > 65535) ? 16'hffff : len[15:0];
        t.last   = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    task automatic predict_char(input logic [7:0] c);
        int unsigned p;
        int unsigned start;
        int          n0;
        bit          taken;
        string       w;
        p     = line_pos;
        start = tok_begin;
        n0    = expected_tokens.size();
        taken = 1'b0;
        w     = kw_spelling[kw_target];
        case (scan_mode)
            MODE_KEYWORD: begin
                if (is_word_char(c)) begin
                    if (!(kw_pos + 1 < w.len() && c == w[kw_pos + 1]))
                        kw_match = 1'b0;
                    if (kw_pos < 3'd7)
                        kw_pos = kw_pos + 3'd1;
                    taken = 1'b1;
                end else begin
                    if (kw_match && kw_pos + 1 == w.len())
                        push_token(kw_token[kw_target], ERR_NONE, start, p - start);
                    else
                        push_token(TK_ERROR, ERR_KEYWORD, start, p - start);
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (is_num_digit(c) || c == CHAR_DOT) begin
                    if (c == CHAR_DOT)
                        dot_seen = 1'b1;
                    taken = 1'b1;
                end else begin
                    push_token(dot_seen ? TK_FLOAT : TK_INT, ERR_NONE, start, p - start);
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_STRING, MODE_ESCAPE: begin
                if (c == CHAR_NUL) begin
                    push_token(TK_ERROR, ERR_UNTERM, start, p - start);
                    scan_mode = MODE_IDLE;
                end else if (c == CHAR_QUOTE && scan_mode == MODE_STRING) begin
                    push_token(TK_STRING, ERR_NONE, start, p + 1 - start);
                    scan_mode = MODE_IDLE;
                    taken = 1'b1;
                end else begin
                    scan_mode = (c == CHAR_BSLASH) ? MODE_ESCAPE : MODE_STRING;
                    taken = 1'b1;
                end
            end
            default: begin
                scan_mode = MODE_IDLE;
            end
        endcase

        if (!taken) begin
            if (c == CHAR_NUL) begin
                push_token(TK_EOF, ERR_NONE, p, 0);
                clear_scanner();
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
                return;
            end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
                // whitespace between tokens
            end else if (c == CHAR_QUOTE) begin
                scan_mode = MODE_STRING;
                tok_begin = line_pos;
            end else if (c == "G" || c == "S" || c == "t" || c == "f") begin
                scan_mode = MODE_KEYWORD;
                case (c)
                    "G":     kw_target = KW_GET;
                    "S":     kw_target = KW_SET;
                    "t":     kw_target = KW_TRUE;
                    default: kw_target = KW_FALSE;
                endcase
                kw_match  = 1'b1;
                kw_pos    = '0;
                tok_begin = line_pos;
            end else if (is_num_digit(c)) begin
                scan_mode = MODE_NUMBER;
                dot_seen  = 1'b0;
                tok_begin = line_pos;
            end else begin
                push_token(TK_ERROR, ERR_UNEXP, p, 1);
            end
        end

        if (line_pos != LINE_POS_MAX)
            line_pos = line_pos + 16'd1;
        if (expected_tokens.size() > n0)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    task automatic check_token();
        t_token want;
        checked_total++;
        if (expected_tokens.size() == 0) begin
            $error("unexpected token word: kind %0d offset %0d length %0d",
                   i_out_mon.token_kind, i_out_mon.token_offset, i_out_mon.token_length);
            fail_total++;
        end else begin
            want = expected_tokens.pop_front();
            if (i_out_mon.token_kind !== want.kind) begin
                $error("token_kind: expected %0d, actual %0d", want.kind, i_out_mon.token_kind);
                fail_total++;
            end
            if (i_out_mon.error_kind !== want.err) begin
                $error("error_kind: expected %0d, actual %0d", want.err, i_out_mon.error_kind);
                fail_total++;
            end
            if (i_out_mon.token_offset !== want.offset) begin
                $error("token_offset: expected %0d, actual %0d",
                       want.offset, i_out_mon.token_offset);
                fail_total++;
            end
            if (i_out_mon.token_length !== want.length) begin
                $error("token_length: expected %0d, actual %0d",
                       want.length, i_out_mon.token_length);
                fail_total++;
            end
            if (i_out_mon.last_of_run !== want.last) begin
                $error("last_of_run: expected %0d, actual %0d",
                       want.last, i_out_mon.last_of_run);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scanner();
            expected_tokens.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                predict_char(i_in_mon.char_in);
            if (i_out_mon.valid && i_out_mon.ready)
                check_token();
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_tokens.size();
        o_checked    <= checked_total;
    end

endmodule

// ===== tb/testbench.sv =====
// top of the tokenizer testbench: clock, reset, character stimulus and verdict
`timescale 1ns / 1ps
module testbench import clt_pkg::*;;

    localparam int RANDOM_CHARS   = 690;
    localparam int CALM_TAIL      = 100;
    localparam int HOLD_AT        = 120;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk;
    logic i_rst_n;
    bit   sink_ready;
    bit   idle_on;
    bit   hold_done;
    int   stall_left;
    int   tokens_seen;
    int   quiet_cycles;
    int   chars_sent;
    int   fail_count;
    int   pending;
    int   checked;

    logic [7:0] line_bytes[$];
    string      kw_spelling[4] = '{"GET", "SET", "true", "false"};
    string      kw_starts      = "GStf";
    string      word_chars     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    logic [7:0] ws_chars[4]    = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};

    clt_in_if  in_ch();
    clt_out_if out_ch();

    assign out_ch.ready = sink_ready;

    command_line_tokenizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // token receiver with short random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            tokens_seen++;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end else if (!hold_done && tokens_seen >= HOLD_AT) begin
            hold_done  <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            sink_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.char_in <= c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_char(line_bytes[i]);
        line_bytes.delete();
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return word_chars[$urandom_range(0, word_chars.len() - 1)];
    endfunction

    function automatic void add_keyword();
        string w;
        int    shape;
        w     = kw_spelling[$urandom_range(0, 3)];
        shape = $urandom_range(0, 5);
        if (shape <= 2) begin
            push_text(w);
        end else if (shape == 3) begin
            push_text(w);
            repeat ($urandom_range(1, 6)) line_bytes.push_back(rand_letter());
        end else if (shape == 4) begin
            push_text(w.substr(0, $urandom_range(0, w.len() - 2)));
        end else begin
            line_bytes.push_back(kw_starts[$urandom_range(0, 3)]);
            repeat ($urandom_range(0, 9)) line_bytes.push_back(rand_letter());
        end
    endfunction

    function automatic void add_number();
        line_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 3) == 0)
                line_bytes.push_back(CHAR_DOT);
            else
                line_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void add_string(input bit closed);
        logic [7:0] b;
        line_bytes.push_back(CHAR_QUOTE);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 7))
                0: begin
                    line_bytes.push_back(CHAR_BSLASH);
                    line_bytes.push_back(CHAR_QUOTE);
                end
                1: begin
                    line_bytes.push_back(CHAR_BSLASH);
                    line_bytes.push_back("n");
                end
                default: begin
                    b = 8'($urandom_range(1, 255));
                    if (b == CHAR_QUOTE || b == CHAR_BSLASH)
                        b = "s";
                    line_bytes.push_back(b);
                end
            endcase
        end
        if (closed)
            line_bytes.push_back(CHAR_QUOTE);
    endfunction

    function automatic void build_line();
        int  count;
        bit  open_string;
        count       = $urandom_range(1, 6);
        open_string = 1'b0;
        for (int i = 0; i < count && !open_string; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_keyword();
                4, 5:       add_number();
                6, 7: begin
                    open_string = ($urandom_range(0, 9) == 0);
                    add_string(!open_string);
                end
                default:    line_bytes.push_back(8'($urandom_range(1, 255)));
            endcase
            if (!open_string && $urandom_range(0, 5) != 0) begin
                repeat ($urandom_range(1, 2)) begin
                    if ($urandom_range(0, 2) == 0)
                        line_bytes.push_back(ws_chars[$urandom_range(0, 3)]);
                    else
                        line_bytes.push_back(CHAR_SPACE);
                end
            end
        end
        line_bytes.push_back(CHAR_NUL);
    endfunction

    initial begin
        int random_start;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.char_in <= 8'h00;
        idle_on        = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keywords good and bad, a keyword cut short by a digit, float
        push_text("GET SETx t1.2.");
        line_bytes.push_back(CHAR_NUL);
        // escaped quote, lone backslash, high byte, number closed by end of line
        push_text("\"a\\\"\\b\"");
        line_bytes.push_back(8'hff);
        push_text("7");
        line_bytes.push_back(CHAR_NUL);
        // stray letter, lone dot, string left open at end of line
        push_text("x. \"ab");
        line_bytes.push_back(CHAR_NUL);
        // whitespace kinds, control byte, keyword closed by a bad byte, long run
        line_bytes.push_back(CHAR_TAB);
        line_bytes.push_back(CHAR_CR);
        line_bytes.push_back(CHAR_LF);
        line_bytes.push_back(8'h01);
        push_text(" G");
        line_bytes.push_back(8'h80);
        push_text(" true falsefalsex 3");
        line_bytes.push_back(CHAR_NUL);
        line_bytes.push_back(CHAR_NUL);
        send_line();

        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS) begin
            if (chars_sent - random_start > RANDOM_CHARS - CALM_TAIL)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
                line_bytes.push_back(CHAR_NUL);
            end else begin
                build_line();
            end
            send_line();
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run sent %0d characters and checked %0d token words", chars_sent, checked);
        $display("including escaped strings, raw byte lines and a long receiver hold-off");
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
